FILE: src/mfb_pkg.sv
// mfb_pkg: shared types, codes and the 5x7 font table for the framebuffer drawing engine
// no dependencies; imported by mfb_store, mfb_seq, the top level, mfb_checker and tb
package mfb_pkg;

    // command codes carried on the input tuser
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_UNSET = 3'd2;
    localparam logic [2:0] ACT_CHAR  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // font coverage and lowercase folding
    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST  = 8'd90;
    localparam logic [7:0] LOWER_FIRST = 8'd97;
    localparam logic [7:0] LOWER_LAST  = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAN_RD,
        ST_SPAN_WR,
        ST_GLY_CHK,
        ST_GLY_WR,
        ST_RD_OUT
    } mfb_state_t;

    // read-back result handed to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } mfb_result_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic ready;
        logic clearing;
        logic writing;
    } mfb_status_t;

    // one glyph per entry, column 0 in bits 7:0 up to column 4 in bits 39:32
    localparam logic [39:0] GLYPH_ROM [0:58] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h12_2A_7F_2A_24, 40'h62_64_08_13_23, 40'h50_22_55_49_36, 40'h00_00_03_05_00,
        40'h00_41_22_1C_00, 40'h00_1C_22_41_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
        40'h00_00_30_50_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h02_04_08_10_20,
        40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
        40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
        40'h36_49_49_49_36, 40'h1E_29_49_49_06, 40'h00_00_36_36_00, 40'h00_00_36_56_00,
        40'h41_22_14_08_00, 40'h14_14_14_14_14, 40'h00_08_14_22_41, 40'h06_09_51_01_02,
        40'h3E_41_79_49_32, 40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E,
        40'h1C_22_41_41_7F, 40'h41_49_49_49_7F, 40'h01_01_09_09_7F, 40'h32_51_41_41_3E,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F,
        40'h40_40_40_40_7F, 40'h7F_02_04_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E,
        40'h06_09_09_09_7F, 40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h31_49_49_49_46,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
        40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h43_45_49_51_61
    };

endpackage

FILE: src/mono_framebuffer_span_and_text_draw_top.sv
// Framebuffer drawing engine: clear, span, 2x char, read; one command at a time.
// After acceptance: a span reads and writes back each clipped column; a char walks 30 page/column
// slots and reads and writes back each slot that carries pixels; a read hands one byte to the result;
// a clear zeroes all STORE_BYTES bytes. Every touched byte is read, then written in a separate state.
// Synchronous active-low reset; afterwards a zero sweep over all STORE_BYTES bytes
// (1024 by default) runs with s_tready low.
module mono_framebuffer_span_and_text_draw_top
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // x_start[8:0], x_end[17:9], row_y[25:18],
                                  // char_code[33:26], read_index[43:34], zero[47:44]
    input  logic [2:0]  s_tuser,  // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // read_data[7:0]
);

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    mfb_result_t   result;
    mfb_status_t   status;
    logic          res_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;

    assign s_tready = status.ready;
    assign res_free = !m_tvalid_reg || m_tready;

    mfb_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .AW            (AW)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_action     (s_tuser),
        .in_x_start    (s_tdata[8:0]),
        .in_x_end      (s_tdata[17:9]),
        .in_row_y      (s_tdata[25:18]),
        .in_char_code  (s_tdata[33:26]),
        .in_read_index (s_tdata[43:34]),
        .res_free      (res_free),
        .result        (result),
        .status        (status),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    mfb_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // output register for read-back transactions
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (result.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = result.data;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the zero sweep runs right after reset, with no transaction taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> (status.clearing && !s_tready))
        else $error("zero sweep not running after reset");

    // a result is only produced when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> res_free)
        else $error("result produced while output register is occupied");

    // store writes only in sweep or write-back states, never during command acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (!s_tready && (status.writing || status.clearing)))
        else $error("store written while accepting a new command");

    // a new result shows up on the output the cycle after it is produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |=> (m_tvalid && (m_tdata == $past(result.data))))
        else $error("result not captured by the output register");

endmodule

FILE: src/mfb_store.sv
// mfb_store: page-wise framebuffer byte memory, one write and one registered read per cycle
// depends on mfb_pkg
module mfb_store
    import mfb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mfb_seq.sv
// mfb_seq: command sequencer with one shared address unit and byte merge unit
// depends on mfb_pkg; drives the mfb_store ports
module mfb_seq
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int AW            = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [2:0]    in_action,
    input  logic [8:0]    in_x_start,
    input  logic [8:0]    in_x_end,
    input  logic [7:0]    in_row_y,
    input  logic [7:0]    in_char_code,
    input  logic [9:0]    in_read_index,
    input  logic          res_free,
    output mfb_result_t   result,
    output mfb_status_t   status,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [3:0] LAST_PAGE = 4'(PAGES - 1);
    localparam logic [7:0] LAST_MASK = (SCREEN_HEIGHT % 8 == 0) ? 8'hFF :
                                       8'((1 << (SCREEN_HEIGHT % 8)) - 1);
    localparam logic signed [9:0] XMAX = 10'(SCREEN_WIDTH - 1);
    localparam logic signed [8:0] YLIM = 9'(SCREEN_HEIGHT);
    localparam logic signed [6:0] PLIM = 7'(PAGES);

    mfb_state_t state_reg, state_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic signed [9:0]  x_reg, x_next;
    logic signed [9:0]  x_end_reg, x_end_next;
    logic [3:0]         page_reg, page_next;
    logic               set_reg, set_next;
    logic [7:0]         mask_reg, mask_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [39:0]        glyph_reg, glyph_next;
    logic signed [5:0]  pg_reg, pg_next;
    logic [2:0]         off_reg, off_next;
    logic [3:0]         col_reg, col_next;
    logic [1:0]         k_reg, k_next;

    // input decode
    logic signed [9:0] xs_ext, xe_ext, x0, x1;
    logic signed [8:0] ry_ext;
    logic              y_ok;
    logic [7:0]        code_f, code_s;
    logic [5:0]        sel;
    logic [12:0]       idx_ext;
    logic              idx_ok;

    assign xs_ext  = {in_x_start[8], in_x_start};
    assign xe_ext  = {in_x_end[8], in_x_end};
    assign x0      = xs_ext[9] ? 10'sd0 : xs_ext;
    assign x1      = (xe_ext > XMAX) ? XMAX : xe_ext;
    assign ry_ext  = {in_row_y[7], in_row_y};
    assign y_ok    = !in_row_y[7] && (ry_ext < YLIM);
    assign code_f  = (in_char_code >= LOWER_FIRST && in_char_code <= LOWER_LAST) ?
                     in_char_code - CASE_OFFSET : in_char_code;
    assign code_s  = (code_f < GLYPH_FIRST || code_f > GLYPH_LAST) ? GLYPH_FIRST : code_f;
    assign sel     = 6'(code_s - GLYPH_FIRST);
    assign idx_ext = {3'b000, in_read_index};
    assign idx_ok  = idx_ext < 13'(STORE_BYTES);

    // glyph slot: one column of one page per slot
    logic [6:0]        gbits;
    logic [13:0]       m14;
    logic [23:0]       shifted;
    logic [7:0]        gbyte, gmask;
    logic signed [6:0] gpage;
    logic signed [9:0] gx;
    logic              g_hit, slot_last;

    assign gbits = glyph_reg[8 * col_reg[3:1] +: 7];

    always_comb begin
        for (int r = 0; r < 7; r++) begin
            m14[2 * r]     = gbits[r];
            m14[2 * r + 1] = gbits[r];
        end
    end

    assign shifted   = 24'(m14) << off_reg;
    assign gbyte     = shifted[8 * k_reg +: 8];
    assign gpage     = {pg_reg[5], pg_reg} + {5'b00000, k_reg};
    assign gx        = x_reg + {6'b000000, col_reg};
    assign gmask     = gbyte & ((gpage[3:0] == LAST_PAGE) ? LAST_MASK : 8'hFF);
    assign g_hit     = !gpage[6] && (gpage < PLIM) && !gx[9] && (gx <= XMAX)
                       && (gmask != 8'h00);
    assign slot_last = (col_reg == 4'd9) && (k_reg == 2'd2);

    // shared address unit: page * width + column
    logic [3:0]  au_page;
    logic [7:0]  au_col;
    logic [12:0] au_sum;
    logic [AW-1:0] au_addr;

    assign au_page = (state_reg == ST_GLY_CHK) ? gpage[3:0] : page_reg;
    assign au_col  = (state_reg == ST_GLY_CHK) ? gx[7:0] : x_reg[7:0];
    assign au_sum  = 13'(au_page) * 13'(SCREEN_WIDTH) + 13'(au_col);
    assign au_addr = au_sum[AW-1:0];

    // shared merge unit: read-modify-write of one byte
    logic [7:0] merged;
    assign merged = set_reg ? (mem_rdata | mask_reg) : (mem_rdata & ~mask_reg);

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        x_reg     <= x_next;
        x_end_reg <= x_end_next;
        page_reg  <= page_next;
        set_reg   <= set_next;
        mask_reg  <= mask_next;
        addr_reg  <= addr_next;
        rd_ok_reg <= rd_ok_next;
        glyph_reg <= glyph_next;
        pg_reg    <= pg_next;
        off_reg   <= off_next;
        col_reg   <= col_next;
        k_reg     <= k_next;
    end

    // next state and outputs
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        x_end_next  = x_end_reg;
        page_next   = page_reg;
        set_next    = set_reg;
        mask_next   = mask_reg;
        addr_next   = addr_reg;
        rd_ok_next  = rd_ok_reg;
        glyph_next  = glyph_reg;
        pg_next     = pg_reg;
        off_next    = off_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = merged;
        mem_raddr   = addr_reg;
        result      = '{valid: 1'b0, data: 8'h00};
        status      = '{ready: 1'b0, clearing: 1'b0, writing: 1'b0};

        case (state_reg)
            // zero sweep over the whole store
            ST_CLEAR: begin
                status.clearing = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = 8'h00;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            // command decode
            ST_IDLE: begin
                status.ready = 1'b1;
                if (in_valid) begin
                    case (in_action)
                        ACT_CLEAR: begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        ACT_SET, ACT_UNSET: begin
                            x_next     = x0;
                            x_end_next = x1;
                            page_next  = in_row_y[6:3];
                            mask_next  = 8'h01 << in_row_y[2:0];
                            set_next   = (in_action == ACT_SET);
                            if (y_ok && (x0 <= x1)) begin
                                state_next = ST_SPAN_RD;
                            end
                        end
                        ACT_CHAR: begin
                            glyph_next = GLYPH_ROM[sel];
                            x_next     = xs_ext;
                            pg_next    = 6'(ry_ext >>> 3);
                            off_next   = in_row_y[2:0];
                            col_next   = 4'd0;
                            k_next     = 2'd0;
                            set_next   = 1'b1;
                            state_next = ST_GLY_CHK;
                        end
                        ACT_READ: begin
                            addr_next  = idx_ext[AW-1:0];
                            mem_raddr  = idx_ext[AW-1:0];
                            rd_ok_next = idx_ok;
                            state_next = ST_RD_OUT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // span: fetch the byte of the current column
            ST_SPAN_RD: begin
                mem_raddr  = au_addr;
                addr_next  = au_addr;
                state_next = ST_SPAN_WR;
            end
            // span: write back and step the column
            ST_SPAN_WR: begin
                mem_we = 1'b1;
                status.writing = 1'b1;
                x_next = x_reg + 10'sd1;
                if (x_reg == x_end_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SPAN_RD;
                end
            end
            // glyph: test the slot, fetch its byte if it has pixels
            ST_GLY_CHK: begin
                if (g_hit) begin
                    mem_raddr  = au_addr;
                    addr_next  = au_addr;
                    mask_next  = gmask;
                    state_next = ST_GLY_WR;
                end else begin
                    if (k_reg == 2'd2) begin
                        k_next   = 2'd0;
                        col_next = col_reg + 4'd1;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                    if (slot_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            // glyph: write back and step the slot
            ST_GLY_WR: begin
                mem_we = 1'b1;
                status.writing = 1'b1;
                if (k_reg == 2'd2) begin
                    k_next   = 2'd0;
                    col_next = col_reg + 4'd1;
                end else begin
                    k_next = k_reg + 2'd1;
                end
                if (slot_last) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_GLY_CHK;
                end
            end
            // read-back: hand the byte over once the output register is free
            ST_RD_OUT: begin
                if (res_free) begin
                    result.valid = 1'b1;
                    result.data  = rd_ok_reg ? mem_rdata : 8'h00;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: dv/mfb_checker.sv
// mfb_checker: watches both stream channels of the framebuffer drawing engine and keeps its
// own page-mode pixel store, predicting every read-back byte and comparing it on arrival
// depends on mfb_pkg for the command codes
module mfb_checker
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          errors,
    output int          reads_pending,
    output int          n_cmds,
    output int          n_spans,
    output int          n_glyphs,
    output int          n_clears,
    output int          n_reads_checked
);

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;

    // font coverage and lowercase folding
    localparam int FONT_LO    = 32;
    localparam int FONT_HI    = 90;
    localparam int LC_A       = 97;
    localparam int LC_Z       = 122;
    localparam int CASE_SHIFT = 32;

    // 5x7 font, column 0 in the top byte down to column 4 in the bottom byte, bit 0 = top row
    localparam logic [39:0] FONT_COLS [0:58] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
        40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
        40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
    };

    logic [7:0] pixel_bytes [0:STORE_BYTES-1];
    logic [7:0] read_byte_q [$];
    logic [7:0] want;

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // single pixel, dropped when off screen
    task automatic plot(int x, int y, bit on);
        int addr;
        if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
            return;
        addr = (y / 8) * SCREEN_WIDTH + x;
        pixel_bytes[addr][y % 8] = on;
    endtask

    task automatic paint_span(int x0, int x1, int y, bit on);
        if (x0 < 0)
            x0 = 0;
        if (x1 > SCREEN_WIDTH - 1)
            x1 = SCREEN_WIDTH - 1;
        for (int x = x0; x <= x1; x++)
            plot(x, y, on);
    endtask

    // each font pixel becomes a 2x2 block
    task automatic paint_glyph(int px, int py, int code);
        int         sel;
        logic [7:0] col_bits;
        if (code >= LC_A && code <= LC_Z)
            code -= CASE_SHIFT;
        if (code < FONT_LO || code > FONT_HI)
            code = FONT_LO;
        sel = code - FONT_LO;
        for (int c = 0; c < 5; c++) begin
            col_bits = FONT_COLS[sel][39 - 8 * c -: 8];
            for (int r = 0; r < 7; r++) begin
                if (col_bits[r]) begin
                    plot(px + 2 * c,     py + 2 * r,     1'b1);
                    plot(px + 2 * c + 1, py + 2 * r,     1'b1);
                    plot(px + 2 * c,     py + 2 * r + 1, 1'b1);
                    plot(px + 2 * c + 1, py + 2 * r + 1, 1'b1);
                end
            end
        end
    endtask

    // apply one accepted command to the pixel store
    task automatic apply_command(logic [2:0] act, logic [47:0] d);
        int xs;
        int xe;
        int ry;
        xs = $signed(d[8:0]);
        xe = $signed(d[17:9]);
        ry = $signed(d[25:18]);
        n_cmds++;
        case (act)
            ACT_CLEAR: begin
                foreach (pixel_bytes[i])
                    pixel_bytes[i] = '0;
                n_clears++;
            end
            ACT_SET: begin
                paint_span(xs, xe, ry, 1'b1);
                n_spans++;
            end
            ACT_UNSET: begin
                paint_span(xs, xe, ry, 1'b0);
                n_spans++;
            end
            ACT_CHAR: begin
                paint_glyph(xs, ry, int'(d[33:26]));
                n_glyphs++;
            end
            ACT_READ: begin
                if (int'(d[43:34]) < STORE_BYTES)
                    read_byte_q.push_back(pixel_bytes[d[43:34]]);
                else
                    read_byte_q.push_back(8'h00);
            end
            default: ;
        endcase
    endtask

    // results are checked before the command of the same edge is applied
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (pixel_bytes[i])
                pixel_bytes[i] = '0;
            read_byte_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (read_byte_q.size() == 0) begin
                    report_mismatch($sformatf("read_data %02h with no read pending", m_tdata));
                end else begin
                    want = read_byte_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("read_data got %02h want %02h",
                                                  m_tdata, want));
                    n_reads_checked++;
                end
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata);
        end
        reads_pending = read_byte_q.size();
    end

endmodule

FILE: dv/tb.sv
// tb: stimulus and verdict for the framebuffer drawing engine, directed commands then
// random spans, glyphs, clears and read-backs under varying idle patterns on both sides
// depends on mfb_pkg, mono_framebuffer_span_and_text_draw_top and mfb_checker
module tb
    import mfb_pkg::*;
();

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 1200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = ACT_READ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int errors;
    int reads_pending;
    int n_cmds;
    int n_spans;
    int n_glyphs;
    int n_clears;
    int n_reads_checked;

    int snd_idle = 0;
    int rcv_idle = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int last_x = 0;
    int last_y = 0;

    always #10 aclk = ~aclk;

    mono_framebuffer_span_and_text_draw_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mfb_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .errors          (errors),
        .reads_pending   (reads_pending),
        .n_cmds          (n_cmds),
        .n_spans         (n_spans),
        .n_glyphs        (n_glyphs),
        .n_clears        (n_clears),
        .n_reads_checked (n_reads_checked)
    );

    // result side: random backpressure, or a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done++;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    // one command transaction, entered and left just after a falling edge
    task automatic send_cmd(logic [2:0] act, int xs, int xe, int ry, int code, int idx);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, 10'(idx), 8'(code), 8'(ry), 9'(xe), 9'(xs)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // random traffic, mostly on-screen drawing and read-backs near the last drawing
    task automatic run_phase(int n_items, int snd_pct, int rcv_pct, bit with_hold);
        int         pick;
        logic [2:0] act;
        int         xs;
        int         xe;
        int         ry;
        int         code;
        int         idx;
        snd_idle = snd_pct;
        rcv_idle = rcv_pct;
        for (int k = 0; k < n_items; k++) begin
            if (with_hold && k == n_items / 2)
                hold_asked++;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                act = ACT_CLEAR;
            else if (pick < 27)
                act = ACT_SET;
            else if (pick < 39)
                act = ACT_UNSET;
            else if (pick < 64)
                act = ACT_CHAR;
            else if (pick < 97)
                act = ACT_READ;
            else
                act = 3'(ACT_READ + $urandom_range(1, 3));
            xs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) - 256
                                             : $urandom_range(0, 139) - 10;
            xe = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) - 256
                                             : xs + $urandom_range(0, 44) - 4;
            ry = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) - 128
                                             : $urandom_range(0, 71) - 4;
            code = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(32, 122);
            if ($urandom_range(0, 3) == 0)
                idx = $urandom_range(0, 1023);
            else
                idx = (((last_y + $urandom_range(0, 14)) & 63) / 8) * 128
                      + ((last_x + $urandom_range(0, 12)) & 127);
            if (act == ACT_SET || act == ACT_UNSET || act == ACT_CHAR) begin
                last_x = xs;
                last_y = ry;
            end
            send_cmd(act, xs, xe, ry, code, idx);
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: clipping, empty spans, folding, blank codes, spare actions
        snd_idle = 7;
        rcv_idle = 72;
        send_cmd(ACT_READ,  0, 0, 0, 0, 0);
        send_cmd(ACT_SET,   -256, 255, 0, 0, 0);
        send_cmd(ACT_READ,  0, 0, 0, 0, 0);
        send_cmd(ACT_READ,  0, 0, 0, 0, 127);
        send_cmd(ACT_SET,   0, 127, 63, 0, 0);
        send_cmd(ACT_READ,  0, 0, 0, 0, 1023);
        send_cmd(ACT_UNSET, 10, 20, 0, 0, 0);
        send_cmd(ACT_SET,   50, 40, 5, 0, 0);
        send_cmd(ACT_SET,   -256, -1, 7, 0, 0);
        send_cmd(ACT_SET,   0, 127, -128, 0, 0);
        send_cmd(ACT_SET,   0, 127, 127, 0, 0);
        send_cmd(ACT_CHAR,  0, 0, 8, 65, 0);
        send_cmd(ACT_CHAR,  120, 0, 56, 97, 0);
        send_cmd(ACT_CHAR,  30, 0, 20, 255, 0);
        send_cmd(ACT_CHAR,  -5, 0, -6, 90, 0);
        send_cmd(ACT_CHAR,  100, 0, 40, 122, 0);
        send_cmd(3'(ACT_READ + 1), 255, -256, 127, 255, 1023);
        send_cmd(3'(ACT_READ + 2), 0, 0, 0, 0, 0);
        send_cmd(3'(ACT_READ + 3), 1, 1, 1, 1, 1);
        send_cmd(ACT_READ,  0, 0, 0, 0, 15);
        send_cmd(ACT_READ,  0, 0, 0, 0, 136);
        send_cmd(ACT_READ,  0, 0, 0, 0, 7 * 128 + 122);
        send_cmd(ACT_CLEAR, 0, 0, 0, 0, 0);
        send_cmd(ACT_READ,  0, 0, 0, 0, 136);

        // random phases with shifting idle patterns
        run_phase(217, 7, 72, 1'b1);
        run_phase(217, 72, 7, 1'b0);
        run_phase(216, 0, 0, 1'b1);
        s_tvalid <= 1'b0;

        // drain, then allow a trailing clear to finish
        while (reads_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d commands: %0d spans, %0d glyphs, %0d full clears",
                 n_cmds, n_spans, n_glyphs, n_clears);
        $display("%0d read-back bytes compared, %0d mismatches", n_reads_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #64_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
